@@ design/mexp_pkg.sv @@
`timescale 1ns / 1ps

package mexp_pkg;

  // default operand width, 8 to 64 bits
  localparam int OPERAND_WIDTH_DEFAULT = 64;

  // reset value of the modulus, 2^64 - 59
  localparam logic [63:0] DEFAULT_MODULUS = 64'hFFFF_FFFF_FFFF_FFC5;

  // register index port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 2'd1;

  // sequencer states
  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] S_REDUCE = 3'd1;
  localparam logic [STATE_W-1:0] S_STEP   = 3'd2;
  localparam logic [STATE_W-1:0] S_MUL    = 3'd3;
  localparam logic [STATE_W-1:0] S_SQR    = 3'd4;

endpackage

@@ design/mexp_mulmod.sv @@
`timescale 1ns / 1ps

// Bit-serial modular multiplier: product = a * b mod m.
// Scans b MSB first, one bit per cycle: acc = 2*acc + bit*a, then reduce.
// Needs acc < m and a < m; b may be any value (a = 1 gives b mod m).
module mexp_mulmod #(
  parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] product
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     acc;
  logic [W-1:0]     a_q;
  logic [W-1:0]     m_q;
  logic [W-1:0]     b_sh;

  logic [W+1:0] sum;
  logic [W+1:0] m1;
  logic [W+1:0] m2;
  logic [W-1:0] acc_next;

  // sum < 3m, so at most two subtractions of m
  always_comb begin
    sum = {1'b0, acc, 1'b0} + {2'b00, (b_sh[W-1] ? a_q : {W{1'b0}})};
    m1  = {2'b00, m_q};
    m2  = {1'b0, m_q, 1'b0};
    if (sum >= m2) begin
      acc_next = W'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = W'(sum - m1);
    end else begin
      acc_next = W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_q  <= a;
      m_q  <= m;
      b_sh <= b;
    end else if (run) begin
      acc  <= acc_next;
      b_sh <= {b_sh[W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

@@ design/modular_exponentiation_64.sv @@
`timescale 1ns / 1ps

// Modular exponentiation: power_result = base_value ^ secret_exponent mod modulus.
// Request channel: base_value is taken at a clock edge with start high and busy
// low. busy stays high until the result is out. The result shows on power_result
// for exactly one cycle with done high; the receiver cannot stall it. A new
// request can be taken in the cycle done is high.
// Configuration: cfg_index / cfg_data written when cfg_valid is high (cfg_ready
// is always high). Index 0 is the modulus, index 1 the exponent; other indexes
// are ignored. Write only while busy is low.
// Operation: one bit-serial modular multiplier, one operand bit per cycle. The
// base is first reduced by one multiplier pass, then the exponent is scanned
// from its low bit: each bit below the top set bit costs a square of the base
// and each one bit a multiply into the result, with a sequencing step in
// S_STEP before each pass. A zero exponent gives 1; a modulus below 2 gives 0
// in the cycle after the request.
// Reset loads modulus = 2^64 - 59 (truncated to W bits) and exponent = 0, and
// drops any request in progress.
module modular_exponentiation_64 #(
  parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [OPERAND_WIDTH-1:0]         base_value,
  output logic                             done,
  output logic [OPERAND_WIDTH-1:0]         power_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [OPERAND_WIDTH-1:0]         cfg_data
);

  localparam int W = OPERAND_WIDTH;
  localparam logic [W-1:0] MOD_RESET = W'(mexp_pkg::DEFAULT_MODULUS);
  localparam logic [W-1:0] ONE       = W'(1);
  localparam logic [W-1:0] TWO       = W'(2);

  logic [W-1:0] modulus;
  logic [W-1:0] secret_exponent;

  logic [mexp_pkg::STATE_W-1:0] state;
  logic [W-1:0] exp_sh;
  logic [W-1:0] base_r;
  logic [W-1:0] acc_r;

  logic         mul_start;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_product;

  logic accept;
  logic mod_small;

  assign cfg_ready = 1'b1;
  assign busy      = (state != mexp_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign mod_small = (modulus < TWO);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= MOD_RESET;
      secret_exponent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mexp_pkg::REG_MODULUS:  modulus         <= cfg_data;
        mexp_pkg::REG_EXPONENT: secret_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = base_r;
    mul_b     = base_r;
    case (state)
      mexp_pkg::S_IDLE: begin
        // base mod m as 1 * base mod m
        mul_start = accept && !mod_small;
        mul_a     = ONE;
        mul_b     = base_value;
      end
      mexp_pkg::S_STEP: begin
        if (exp_sh[0]) begin
          mul_start = 1'b1;
          mul_a     = acc_r;
        end else begin
          mul_start = (exp_sh != '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        mexp_pkg::S_IDLE: begin
          if (accept) begin
            if (mod_small) begin
              done <= 1'b1;
            end else begin
              state <= mexp_pkg::S_REDUCE;
            end
          end
        end
        mexp_pkg::S_REDUCE: begin
          if (mul_done) state <= mexp_pkg::S_STEP;
        end
        mexp_pkg::S_STEP: begin
          if (exp_sh[0]) begin
            state <= mexp_pkg::S_MUL;
          end else if (exp_sh != '0) begin
            state <= mexp_pkg::S_SQR;
          end else begin
            state <= mexp_pkg::S_IDLE;
            done  <= 1'b1;
          end
        end
        mexp_pkg::S_MUL: begin
          if (mul_done) state <= mexp_pkg::S_STEP;
        end
        mexp_pkg::S_SQR: begin
          if (mul_done) state <= mexp_pkg::S_STEP;
        end
        default: state <= mexp_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mexp_pkg::S_IDLE: begin
        if (accept) begin
          exp_sh       <= secret_exponent;
          acc_r        <= ONE;
          power_result <= '0;
        end
      end
      mexp_pkg::S_REDUCE: begin
        if (mul_done) base_r <= mul_product;
      end
      mexp_pkg::S_STEP: begin
        if (!exp_sh[0]) begin
          exp_sh <= exp_sh >> 1;
          if (exp_sh == '0) power_result <= acc_r;
        end
      end
      mexp_pkg::S_MUL: begin
        if (mul_done) begin
          acc_r     <= mul_product;
          exp_sh[0] <= 1'b0;
        end
      end
      mexp_pkg::S_SQR: begin
        if (mul_done) base_r <= mul_product;
      end
      default: ;
    endcase
  end

  mexp_mulmod #(
    .OPERAND_WIDTH(W)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (modulus),
    .done   (mul_done),
    .product(mul_product)
  );

  // a result comes only from a small-modulus request or the last exponent step
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept && mod_small) ||
              $past(state == mexp_pkg::S_STEP && exp_sh == '0)))
    else $error("done without a finished request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == mexp_pkg::S_REDUCE || state == mexp_pkg::S_MUL ||
                  state == mexp_pkg::S_SQR))
    else $error("multiplier finished outside a multiply state");

  a_small_mod: assert property (@(posedge clk) disable iff (rst)
    (accept && mod_small) |=> (done && power_result == '0))
    else $error("modulus below two did not give zero at once");

endmodule
